// ===== sv/plist_pkg.sv =====
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and codes for the positional list block.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int FUNC_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_PEEK   = 2'd2,
    FN_RSVD   = 2'd3
  } func_t;

  typedef enum logic {
    OS_IDLE = 1'b0,
    OS_HOLD = 1'b1
  } out_state_t;

  typedef struct packed {
    logic exec;
  } plist_cmd_t;

endpackage

// ===== sv/positional_list_insert_remove_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_remove_top
// Ordered list of up to DEPTH entries with insert, remove and peek by
// position.
// ----------------------------------------------------------------------------
// Each input beat carries one operation and yields exactly one result beat,
// presented the cycle after acceptance from an output register. One operation
// completes per clock: every entry cell shifts toward or away from its
// neighbor in the same cycle, so insert and remove take equally long whatever
// the position. The input stalls only while a result waits and m_axis_tready
// is low. Refused operations (insert when full or past the end, remove or
// peek past the end, the reserved code) leave the list unchanged and set
// status. Entries hold no reset value; only entries below the count are read.
module positional_list_insert_remove_top #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // position, item_value
  input  logic [((($clog2(DEPTH) + ITEM_WIDTH) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // func
  input  logic [plist_pkg::FUNC_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // read_value, item_count, is_full, is_empty, status
  output logic [(((ITEM_WIDTH + $clog2(DEPTH + 1) + 3) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OUT_W = (((ITEM_WIDTH + CW + 3) + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - (ITEM_WIDTH + CW + 3);

  plist_pkg::plist_cmd_t cmd;
  logic [ITEM_WIDTH-1:0] read_value;
  logic [CW-1:0]         item_count;
  logic                  is_full;
  logic                  is_empty;
  logic                  status;

  plist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  plist_dp #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH),
    .PW         (PW),
    .CW         (CW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (s_axis_tuser),
    .position   (s_axis_tdata[PW-1:0]),
    .item_value (s_axis_tdata[PW +: ITEM_WIDTH]),
    .read_value (read_value),
    .item_count (item_count),
    .is_full    (is_full),
    .is_empty   (is_empty),
    .status     (status)
  );

  if (PAD_W > 0) begin : g_pad
    assign m_axis_tdata = {{PAD_W{1'b0}}, status, is_empty, is_full, item_count, read_value};
  end else begin : g_nopad
    assign m_axis_tdata = {status, is_empty, is_full, item_count, read_value};
  end

endmodule

// ===== sv/plist_ctrl.sv =====
// ----------------------------------------------------------------------------
// plist_ctrl
// Handshake controller: tracks whether a result beat is held in the output
// register and issues the execute command for each accepted input beat.
// ----------------------------------------------------------------------------
module plist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output plist_pkg::plist_cmd_t cmd
);

  plist_pkg::out_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plist_pkg::OS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.exec   = 1'b0;
    state_next = state;
    unique case (state)
      plist_pkg::OS_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
        if (in_valid) begin
          state_next = plist_pkg::OS_HOLD;
        end
      end
      plist_pkg::OS_HOLD: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        cmd.exec  = in_valid && out_ready;
        if (out_ready && !in_valid) begin
          state_next = plist_pkg::OS_IDLE;
        end
      end
      default: begin
        state_next = plist_pkg::OS_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/plist_dp.sv =====
// ----------------------------------------------------------------------------
// plist_dp
// Datapath: a row of entry cells that shift in parallel, the entry count,
// and the registered result fields.
// ----------------------------------------------------------------------------
module plist_dp #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32,
  parameter int PW         = $clog2(DEPTH),
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  plist_pkg::plist_cmd_t    cmd,
  input  logic [plist_pkg::FUNC_W-1:0] func,
  input  logic [PW-1:0]            position,
  input  logic [ITEM_WIDTH-1:0]    item_value,
  output logic [ITEM_WIDTH-1:0]    read_value,
  output logic [CW-1:0]            item_count,
  output logic                     is_full,
  output logic                     is_empty,
  output logic                     status
);

  logic [ITEM_WIDTH-1:0] cells [DEPTH];
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         pos_ext;
  logic                  ins_ok;
  logic                  rem_ok;
  logic                  peek_ok;

  assign pos_ext = CW'(position);

  always_comb begin
    ins_ok  = 1'b0;
    rem_ok  = 1'b0;
    peek_ok = 1'b0;
    unique case (plist_pkg::func_t'(func))
      plist_pkg::FN_INSERT: ins_ok  = (count < CW'(DEPTH)) && (pos_ext <= count);
      plist_pkg::FN_REMOVE: rem_ok  = pos_ext < count;
      plist_pkg::FN_PEEK:   peek_ok = pos_ext < count;
      plist_pkg::FN_RSVD:   ;
      default:              ;
    endcase
  end

  always_comb begin
    priority if (ins_ok) begin
      count_next = count + CW'(1);
    end else if (rem_ok) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (ins_ok) begin
          if (CW'(i) == pos_ext) begin
            cells[i] <= item_value;
          end else if (i > 0 && CW'(i) > pos_ext) begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end
        end else if (rem_ok && i < DEPTH - 1 && CW'(i) >= pos_ext) begin
          cells[i] <= cells[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_value <= peek_ok ? cells[position] : '0;
      item_count <= count_next;
      is_full    <= count_next == CW'(DEPTH);
      is_empty   <= count_next == '0;
      status     <= !(ins_ok || rem_ok || peek_ok);
    end
  end

endmodule

// ===== sv/plist_checker.sv =====
// ----------------------------------------------------------------------------
// plist_checker
// Port-level checks for the positional list block, bound to the top level.
// ----------------------------------------------------------------------------
module plist_checker #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [plist_pkg::FUNC_W-1:0] s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [(((ITEM_WIDTH + $clog2(DEPTH + 1) + 3) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt;
  logic          full_f;
  logic          empty_f;
  logic          stat_f;

  assign cnt     = m_axis_tdata[ITEM_WIDTH +: CW];
  assign full_f  = m_axis_tdata[ITEM_WIDTH + CW];
  assign empty_f = m_axis_tdata[ITEM_WIDTH + CW + 1];
  assign stat_f  = m_axis_tdata[ITEM_WIDTH + CW + 2];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> cnt <= CW'(DEPTH) && full_f == (cnt == CW'(DEPTH))
                      && empty_f == (cnt == '0))
    else $error("count and flags disagree");

  a_rsvd: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == plist_pkg::FN_RSVD
      |=> stat_f && m_axis_tdata[ITEM_WIDTH-1:0] == '0)
    else $error("reserved operation not refused");

  a_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready ##1 s_axis_tvalid && s_axis_tready
      && s_axis_tuser == plist_pkg::FN_PEEK
      |=> cnt == $past(cnt, 2) || $past(m_axis_tvalid, 1) == 1'b0
      || cnt == $past(cnt, 1))
    else $error("peek changed the count");

endmodule

bind positional_list_insert_remove_top plist_checker #(
  .DEPTH      (DEPTH),
  .ITEM_WIDTH (ITEM_WIDTH)
) u_plist_checker (.*);

// ===== dv/positional_list_insert_remove_top_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_remove_top_tb
// Self-checking bench for the positional list: insert, remove and peek.
// ----------------------------------------------------------------------------
// A directed run walks the list from empty to full over its edges
// (refused operations, the reserved code, extreme values), then random
// operations alternate between filling and draining phases so the list keeps
// crossing full and empty. A shadow list predicts every result beat, which is
// compared field by field as it leaves the block. Both stream sides throttle
// at random, apart from one long stretch at full rate.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int RANDOM_OPS = 1900;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic        status;
    logic        is_empty;
    logic        is_full;
    logic [4:0]  item_count;
    logic [31:0] read_value;
  } result_t;

  class list_tracker;
    logic [31:0] entries [DEPTH];
    int unsigned fill;
    int unsigned errors;
    result_t     expected_results [$];

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned count();
      return fill;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_op(plist_pkg::func_t f, logic [3:0] pos, logic [31:0] val);
      result_t r;
      int      i;
      r        = '0;
      r.status = 1'b1;
      case (f)
        plist_pkg::FN_INSERT: begin
          if (fill < DEPTH && pos <= fill) begin
            for (i = fill; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = val;
            fill++;
            r.status = 1'b0;
          end
        end
        plist_pkg::FN_REMOVE: begin
          if (pos < fill) begin
            for (i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
            fill--;
            r.status = 1'b0;
          end
        end
        plist_pkg::FN_PEEK: begin
          if (pos < fill) begin
            r.read_value = entries[pos];
            r.status     = 1'b0;
          end
        end
        default: ;
      endcase
      r.item_count = 5'(fill);
      r.is_full    = (fill == DEPTH);
      r.is_empty   = (fill == 0);
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result beat: %h", $realtime, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.read_value !== want.read_value || got.item_count !== want.item_count ||
          got.is_full !== want.is_full || got.is_empty !== want.is_empty ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] mismatch: expected read_value=%h count=%0d full=%b empty=%b ",
                    "status=%b, got read_value=%h count=%0d full=%b empty=%b status=%b"},
                   $realtime, want.read_value, want.item_count, want.is_full,
                   want.is_empty, want.status, got.read_value, got.item_count,
                   got.is_full, got.is_empty, got.status);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // position, item_value
  logic [1:0]  s_axis_tuser = '0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // read_value, item_count, is_full, is_empty, status

  bit          steady = 1'b0;
  int unsigned cycle_count = 0;
  list_tracker tracker;

  positional_list_insert_remove_top #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(result_t'(m_axis_tdata));
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_op(input plist_pkg::func_t f, input logic [3:0] pos,
                         input logic [31:0] val);
    while (!steady && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, val, pos};
    s_axis_tuser  <= f;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_op(f, pos, val);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic send_random_op(input bit filling);
    int unsigned      roll;
    int unsigned      fill;
    plist_pkg::func_t f;
    logic [3:0]       pos;
    roll = $urandom_range(0, 99);
    fill = tracker.count();
    if (roll < 6) begin
      f   = plist_pkg::func_t'($urandom_range(0, 3));
      pos = 4'($urandom_range(0, 15));
    end else begin
      roll = $urandom_range(0, 99);
      if (filling)
        f = (roll < 60) ? plist_pkg::FN_INSERT :
            (roll < 80) ? plist_pkg::FN_REMOVE : plist_pkg::FN_PEEK;
      else
        f = (roll < 25) ? plist_pkg::FN_INSERT :
            (roll < 75) ? plist_pkg::FN_REMOVE : plist_pkg::FN_PEEK;
      if (f == plist_pkg::FN_INSERT)
        pos = 4'($urandom_range(0, (fill < DEPTH) ? fill : DEPTH - 1));
      else if (fill == 0)
        pos = 4'($urandom_range(0, 15));
      else
        pos = 4'($urandom_range(0, fill - 1));
    end
    send_op(f, pos, $urandom());
  endtask

  initial begin
    int         n;
    logic [31:0] v;
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_op(plist_pkg::FN_PEEK, 4'd0, 32'h0);
    send_op(plist_pkg::FN_REMOVE, 4'd0, 32'h0);
    send_op(plist_pkg::FN_RSVD, 4'd0, 32'hFFFF_FFFF);
    send_op(plist_pkg::FN_INSERT, 4'd1, 32'h1234_5678);
    for (n = 0; n < DEPTH; n++) begin
      case (n)
        0:       v = 32'h0000_0000;
        1:       v = 32'hFFFF_FFFF;
        2:       v = 32'h5555_5555;
        3:       v = 32'hAAAA_AAAA;
        default: v = $urandom();
      endcase
      send_op(plist_pkg::FN_INSERT, 4'($urandom_range(0, n)), v);
    end
    send_op(plist_pkg::FN_INSERT, 4'd0, 32'hDEAD_BEEF);
    send_op(plist_pkg::FN_PEEK, 4'd15, 32'h0);
    send_op(plist_pkg::FN_PEEK, 4'd0, 32'h0);
    send_op(plist_pkg::FN_REMOVE, 4'd15, 32'h0);
    send_op(plist_pkg::FN_REMOVE, 4'd15, 32'h0);
    drain_results();

    for (n = 0; n < RANDOM_OPS; n++) begin
      steady = (n >= 600 && n < 900);
      if (n == 1200) drain_results();
      send_random_op(((n / 120) % 2) == 0);
    end
    steady = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
